>>> sv/preorder_tree_rank_validator_macros.svh
// ----------------------------------------------------------------------------
// Preorder tree rank validator assertion macros
// Shared concurrent assertion helpers for the validator RTL.
// ----------------------------------------------------------------------------
`ifndef PREORDER_TREE_RANK_VALIDATOR_MACROS_SVH
`define PREORDER_TREE_RANK_VALIDATOR_MACROS_SVH

`ifndef ASSERT_OFF

`define PTRV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PTRV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PTRV_ASSERT(lbl, clk, rst_n, prop, msg)

`define PTRV_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> sv/ptrv_pkg.sv
// ----------------------------------------------------------------------------
// Preorder tree rank validator package
// Shared sizes, stack entry and result types, datapath operations.
// ----------------------------------------------------------------------------
package ptrv_pkg;

  localparam int MAX_DEPTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int DEPTH_W     = 5;
  localparam int FILL_W      = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W      = $clog2(MAX_DEPTH);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    count_t             index;
    count_t             rank;
    logic               leaf;
  } entry_t;

  typedef struct packed {
    logic   kind;
    count_t node_index;
    count_t node_rank;
    logic   node_ok;
    logic   tree_valid;
    count_t total_nodes;
    count_t total_leaves;
    count_t total_inner;
    count_t highest_rank;
    logic   bifurcating;
    logic   last_result;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_POP,
    OP_POP_FULL,
    OP_FETCH,
    OP_PUSH,
    OP_SUM,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    logic need_pop;
    logic full;
    logic empty;
    logic final_item;
    logic move_ok;
  } status_t;

  function automatic count_t sat_inc(count_t v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> sv/ptrv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptrv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ptrv_ctrl.sv
// ----------------------------------------------------------------------------
// Preorder tree rank validator controller
// Sequences load, pop, refill, push, summary and flush operations of the datapath.
// ----------------------------------------------------------------------------
module ptrv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ptrv_pkg::status_t status_i,
  output ptrv_pkg::op_e     op_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_DRAIN,
    S_DFETCH,
    S_SUM,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = ptrv_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = ptrv_pkg::OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.move_ok) begin
          if (status_i.need_pop) begin
            op_o    = ptrv_pkg::OP_POP;
            state_d = S_FETCH;
          end else if (status_i.full) begin
            op_o    = ptrv_pkg::OP_POP_FULL;
            state_d = S_FETCH;
          end else begin
            op_o    = ptrv_pkg::OP_PUSH;
            state_d = status_i.final_item ? S_DRAIN : S_IDLE;
          end
        end
      end
      S_FETCH: begin
        op_o    = ptrv_pkg::OP_FETCH;
        state_d = S_CHECK;
      end
      S_DRAIN: begin
        if (status_i.move_ok) begin
          if (status_i.empty) begin
            op_o    = ptrv_pkg::OP_SUM;
            state_d = S_FLUSH;
          end else begin
            op_o    = ptrv_pkg::OP_POP;
            state_d = S_DFETCH;
          end
        end
      end
      S_DFETCH: begin
        op_o    = ptrv_pkg::OP_FETCH;
        state_d = S_DRAIN;
      end
      S_SUM: begin
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (status_i.move_ok) begin
          op_o    = ptrv_pkg::OP_FLUSH;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> sv/ptrv_dp.sv
// ----------------------------------------------------------------------------
// Preorder tree rank validator datapath
// Cached stack top, tree statistics, pending result and output register.
// ----------------------------------------------------------------------------
`include "preorder_tree_rank_validator_macros.svh"

module ptrv_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptrv_pkg::op_e                    op_i,
  output ptrv_pkg::status_t                status_o,
  input  logic [ptrv_pkg::DEPTH_W-1:0]     node_depth_i,
  input  logic                             leaf_flag_i,
  input  logic                             final_node_i,
  output logic                             ram_we_o,
  output logic [ptrv_pkg::ADDR_W-1:0]      ram_waddr_o,
  output ptrv_pkg::entry_t                 ram_wdata_o,
  output logic [ptrv_pkg::ADDR_W-1:0]      ram_raddr_o,
  input  ptrv_pkg::entry_t                 ram_rdata_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output ptrv_pkg::result_t                out_o
);

  logic [ptrv_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic                         leaf_q, leaf_d;
  logic                         final_q, final_d;
  ptrv_pkg::entry_t             top_q, top_d;
  ptrv_pkg::result_t            pend_q, pend_d;
  ptrv_pkg::result_t            out_q, out_d;

  logic [ptrv_pkg::DEPTH_W-1:0] prev_depth_q, prev_depth_d;
  logic [ptrv_pkg::FILL_W-1:0]  fill_q, fill_d;
  ptrv_pkg::count_t             node_cnt_q, node_cnt_d;
  ptrv_pkg::count_t             leaf_cnt_q, leaf_cnt_d;
  ptrv_pkg::count_t             rank_max_q, rank_max_d;
  logic                         all_ok_q, all_ok_d;
  logic                         pend_valid_q, pend_valid_d;
  logic                         out_valid_q, out_valid_d;

  logic                         move;
  logic                         move_last;
  logic                         top_ok;
  logic [ptrv_pkg::FILL_W-1:0]  fill_m1;
  logic [ptrv_pkg::FILL_W-1:0]  fill_m2;
  ptrv_pkg::result_t            report;
  ptrv_pkg::result_t            summary;

  assign fill_m1 = fill_q - ptrv_pkg::FILL_W'(1);
  assign fill_m2 = fill_q - ptrv_pkg::FILL_W'(2);

  always_comb begin
    case (top_q.rank)
      ptrv_pkg::count_t'(0): top_ok = top_q.leaf;
      ptrv_pkg::count_t'(1): top_ok = 1'b0;
      default:               top_ok = !top_q.leaf;
    endcase
  end

  always_comb begin
    report            = '0;
    report.kind       = ptrv_pkg::KIND_REPORT;
    report.node_index = top_q.index;
    report.node_rank  = top_q.rank;
    report.node_ok    = top_ok;

    summary              = '0;
    summary.kind         = ptrv_pkg::KIND_SUMMARY;
    summary.tree_valid   = all_ok_q;
    summary.total_nodes  = node_cnt_q;
    summary.total_leaves = leaf_cnt_q;
    summary.total_inner  = (node_cnt_q >= leaf_cnt_q) ? node_cnt_q - leaf_cnt_q : '0;
    summary.highest_rank = rank_max_q;
    summary.bifurcating  = (rank_max_q == ptrv_pkg::count_t'(2));
  end

  always_comb begin
    depth_d      = depth_q;
    leaf_d       = leaf_q;
    final_d      = final_q;
    top_d        = top_q;
    pend_d       = pend_q;
    prev_depth_d = prev_depth_q;
    fill_d       = fill_q;
    node_cnt_d   = node_cnt_q;
    leaf_cnt_d   = leaf_cnt_q;
    rank_max_d   = rank_max_q;
    all_ok_d     = all_ok_q;
    pend_valid_d = pend_valid_q;
    move         = 1'b0;
    move_last    = 1'b0;
    ram_we_o     = 1'b0;
    ram_wdata_o  = top_q;
    ram_wdata_o.rank = ptrv_pkg::sat_inc(top_q.rank);

    case (op_i)
      ptrv_pkg::OP_LOAD: begin
        depth_d      = node_depth_i;
        leaf_d       = leaf_flag_i;
        final_d      = final_node_i;
        prev_depth_d = node_depth_i;
        if ({1'b0, node_depth_i} > {1'b0, prev_depth_q} + 1'b1) begin
          all_ok_d = 1'b0;
        end
      end
      ptrv_pkg::OP_POP, ptrv_pkg::OP_POP_FULL: begin
        move         = pend_valid_q;
        pend_d       = report;
        pend_valid_d = 1'b1;
        fill_d       = fill_m1;
        if (top_q.rank == '0) begin
          leaf_cnt_d = ptrv_pkg::sat_inc(leaf_cnt_q);
        end
        if (top_q.rank > rank_max_q) begin
          rank_max_d = top_q.rank;
        end
        if (!top_ok || (op_i == ptrv_pkg::OP_POP_FULL)) begin
          all_ok_d = 1'b0;
        end
      end
      ptrv_pkg::OP_FETCH: begin
        top_d = ram_rdata_i;
      end
      ptrv_pkg::OP_PUSH: begin
        move         = pend_valid_q;
        move_last    = !final_q;
        pend_valid_d = 1'b0;
        ram_we_o     = (fill_q != '0);
        top_d.depth  = depth_q;
        top_d.index  = node_cnt_q;
        top_d.rank   = '0;
        top_d.leaf   = leaf_q;
        fill_d       = fill_q + 1'b1;
        node_cnt_d   = ptrv_pkg::sat_inc(node_cnt_q);
      end
      ptrv_pkg::OP_SUM: begin
        move         = pend_valid_q;
        pend_d       = summary;
        pend_valid_d = 1'b1;
        prev_depth_d = '0;
        node_cnt_d   = '0;
        leaf_cnt_d   = '0;
        rank_max_d   = '0;
        all_ok_d     = 1'b1;
      end
      ptrv_pkg::OP_FLUSH: begin
        move         = pend_valid_q;
        move_last    = 1'b1;
        pend_valid_d = 1'b0;
      end
      default: begin
      end
    endcase

    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (move) begin
      out_d             = pend_q;
      out_d.last_result = move_last;
      out_valid_d       = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign ram_waddr_o = fill_m1[ptrv_pkg::ADDR_W-1:0];
  assign ram_raddr_o = fill_m2[ptrv_pkg::ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    leaf_q  <= leaf_d;
    final_q <= final_d;
    top_q   <= top_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_depth_q <= '0;
      fill_q       <= '0;
      node_cnt_q   <= '0;
      leaf_cnt_q   <= '0;
      rank_max_q   <= '0;
      all_ok_q     <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      prev_depth_q <= prev_depth_d;
      fill_q       <= fill_d;
      node_cnt_q   <= node_cnt_d;
      leaf_cnt_q   <= leaf_cnt_d;
      rank_max_q   <= rank_max_d;
      all_ok_q     <= all_ok_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign status_o.need_pop   = (fill_q != '0) && (depth_q <= top_q.depth);
  assign status_o.full       = (fill_q == ptrv_pkg::FILL_W'(ptrv_pkg::MAX_DEPTH));
  assign status_o.empty      = (fill_q == '0);
  assign status_o.final_item = final_q;
  assign status_o.move_ok    = !pend_valid_q || !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `PTRV_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= ptrv_pkg::FILL_W'(ptrv_pkg::MAX_DEPTH), "Stack fill exceeds its depth.")
  `PTRV_ASSERT(a_no_pop_empty, clk_i, rst_ni, ((op_i == ptrv_pkg::OP_POP) || (op_i == ptrv_pkg::OP_POP_FULL)) |-> (fill_q != '0), "Pop issued on an empty stack.")
  `PTRV_ASSERT(a_push_grows, clk_i, rst_ni, (op_i == ptrv_pkg::OP_PUSH) |=> (fill_q == $past(fill_q) + 1'b1), "Push did not grow the stack.")
  `PTRV_ASSERT(a_no_overwrite, clk_i, rst_ni, (move && out_valid_q) |-> out_ready_i, "Output item overwritten before it was taken.")
  `PTRV_ASSERT_ALWAYS(a_summary_last, clk_i, (out_valid_q && (out_q.kind == ptrv_pkg::KIND_SUMMARY)) |-> out_q.last_result, "Tree summary not marked as the last result.")

endmodule

>>> sv/preorder_tree_rank_validator.sv
// ----------------------------------------------------------------------------
// Preorder tree rank validator
// Checks node ranks of a preorder tree list and reports a tree summary.
// ----------------------------------------------------------------------------
// A node that closes no entry takes a load step and a push step; the push waits while the output is blocked.
// Each closed node adds a pop step and a stack refill step, since the stack read is registered.
// The final node adds a pop and a refill step per open entry, then a summary step and a flush step.
// Results pass through a pending stage and an output register before they reach the outputs.
// Reset clears the control state and counters; the stack needs no clearing pass.
module preorder_tree_rank_validator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ptrv_pkg::DEPTH_W-1:0]     node_depth_i,
  input  logic                             leaf_flag_i,
  input  logic                             final_node_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kind_o,
  output logic [ptrv_pkg::COUNT_WIDTH-1:0] node_index_o,
  output logic [ptrv_pkg::COUNT_WIDTH-1:0] node_rank_o,
  output logic                             node_ok_o,
  output logic                             tree_valid_o,
  output logic [ptrv_pkg::COUNT_WIDTH-1:0] total_nodes_o,
  output logic [ptrv_pkg::COUNT_WIDTH-1:0] total_leaves_o,
  output logic [ptrv_pkg::COUNT_WIDTH-1:0] total_inner_o,
  output logic [ptrv_pkg::COUNT_WIDTH-1:0] highest_rank_o,
  output logic                             bifurcating_o,
  output logic                             last_result_o
);

  ptrv_pkg::op_e                  op;
  ptrv_pkg::status_t              status;
  logic                           ram_we;
  logic [ptrv_pkg::ADDR_W-1:0]    ram_waddr;
  logic [ptrv_pkg::ADDR_W-1:0]    ram_raddr;
  ptrv_pkg::entry_t               ram_wdata;
  ptrv_pkg::entry_t               ram_rdata;
  ptrv_pkg::result_t              res;

  ptrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .op_o       (op)
  );

  ptrv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .status_o     (status),
    .node_depth_i (node_depth_i),
    .leaf_flag_i  (leaf_flag_i),
    .final_node_i (final_node_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_o        (res)
  );

  ptrv_ram #(
    .WIDTH ($bits(ptrv_pkg::entry_t)),
    .DEPTH (ptrv_pkg::MAX_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign kind_o         = res.kind;
  assign node_index_o   = res.node_index;
  assign node_rank_o    = res.node_rank;
  assign node_ok_o      = res.node_ok;
  assign tree_valid_o   = res.tree_valid;
  assign total_nodes_o  = res.total_nodes;
  assign total_leaves_o = res.total_leaves;
  assign total_inner_o  = res.total_inner;
  assign highest_rank_o = res.highest_rank;
  assign bifurcating_o  = res.bifurcating;
  assign last_result_o  = res.last_result;

endmodule

>>> tb/preorder_tree_rank_validator_test.sv
// ----------------------------------------------------------------------------
// Preorder tree rank validator testbench
// Sends preorder node lists through the validator with random gaps and
// stalls on both handshakes. Every accepted node is run through a local
// model of the open-ancestor stack, and each result that leaves the block
// is compared with the oldest predicted rank report or tree summary.
// ----------------------------------------------------------------------------
module preorder_tree_rank_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS    = 50;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 16;
  localparam int STALL_LIMIT     = 2000;

  typedef logic [ptrv_pkg::DEPTH_W-1:0] depth_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  depth_t                 node_depth_i;
  logic                   leaf_flag_i;
  logic                   final_node_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   kind_o;
  ptrv_pkg::count_t       node_index_o;
  ptrv_pkg::count_t       node_rank_o;
  logic                   node_ok_o;
  logic                   tree_valid_o;
  ptrv_pkg::count_t       total_nodes_o;
  ptrv_pkg::count_t       total_leaves_o;
  ptrv_pkg::count_t       total_inner_o;
  ptrv_pkg::count_t       highest_rank_o;
  logic                   bifurcating_o;
  logic                   last_result_o;

  // Local copy of the open-ancestor stack and the per-tree tallies.
  depth_t            open_depth [ptrv_pkg::MAX_DEPTH];
  ptrv_pkg::count_t  open_index [ptrv_pkg::MAX_DEPTH];
  ptrv_pkg::count_t  open_rank  [ptrv_pkg::MAX_DEPTH];
  logic              open_leaf  [ptrv_pkg::MAX_DEPTH];
  int                open_count;
  int                last_depth;
  ptrv_pkg::count_t  nodes_seen;
  ptrv_pkg::count_t  leaves_seen;
  ptrv_pkg::count_t  widest_rank;
  logic              tree_ok;

  ptrv_pkg::result_t step_results[$];
  ptrv_pkg::result_t awaited_results[$];

  depth_t  shape_depth[$];
  logic    shape_leaf[$];
  logic    shape_final[$];
  int      grow_room;

  int      fault_count = 0;
  int      items_sent  = 0;
  int      quiet_cycles = 0;
  bit      tx_gaps_on = 1'b1;
  bit      rx_gaps_on = 1'b1;
  bit      hold_off_req = 1'b0;

  preorder_tree_rank_validator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .node_depth_i   (node_depth_i),
    .leaf_flag_i    (leaf_flag_i),
    .final_node_i   (final_node_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .node_index_o   (node_index_o),
    .node_rank_o    (node_rank_o),
    .node_ok_o      (node_ok_o),
    .tree_valid_o   (tree_valid_o),
    .total_nodes_o  (total_nodes_o),
    .total_leaves_o (total_leaves_o),
    .total_inner_o  (total_inner_o),
    .highest_rank_o (highest_rank_o),
    .bifurcating_o  (bifurcating_o),
    .last_result_o  (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(0, 2);
    end else if (pick < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_tree_state();
    open_count  = 0;
    last_depth  = 0;
    nodes_seen  = '0;
    leaves_seen = '0;
    widest_rank = '0;
    tree_ok     = 1'b1;
  endfunction

  function automatic void close_top_entry();
    int                t;
    ptrv_pkg::count_t  r;
    logic              lf;
    logic              ok;
    ptrv_pkg::result_t rep;
    t  = open_count - 1;
    r  = open_rank[t];
    lf = open_leaf[t];
    if (r == 0) begin
      ok = lf;
      if (leaves_seen != ptrv_pkg::COUNT_MAX) leaves_seen = leaves_seen + 1'b1;
    end else if (r == 1) begin
      ok = 1'b0;
    end else begin
      ok = !lf;
    end
    if (!ok) tree_ok = 1'b0;
    if (r > widest_rank) widest_rank = r;
    rep            = '0;
    rep.kind       = ptrv_pkg::KIND_REPORT;
    rep.node_index = open_index[t];
    rep.node_rank  = r;
    rep.node_ok    = ok;
    step_results = {step_results, rep};
    open_count = t;
  endfunction

  // Works out every result that one accepted node causes.
  function automatic void track_node(depth_t d, logic lf, logic fin);
    ptrv_pkg::result_t s;
    if (int'(d) > last_depth + 1) tree_ok = 1'b0;
    last_depth = int'(d);
    while (open_count > 0 && d <= open_depth[open_count-1]) close_top_entry();
    if (open_count >= ptrv_pkg::MAX_DEPTH) begin
      tree_ok = 1'b0;
      close_top_entry();
    end
    if (open_count > 0 && open_rank[open_count-1] != ptrv_pkg::COUNT_MAX) begin
      open_rank[open_count-1] = open_rank[open_count-1] + 1'b1;
    end
    open_depth[open_count] = d;
    open_index[open_count] = nodes_seen;
    open_rank[open_count]  = '0;
    open_leaf[open_count]  = lf;
    open_count++;
    if (nodes_seen != ptrv_pkg::COUNT_MAX) nodes_seen = nodes_seen + 1'b1;
    if (fin) begin
      while (open_count > 0) close_top_entry();
      s              = '0;
      s.kind         = ptrv_pkg::KIND_SUMMARY;
      s.tree_valid   = tree_ok;
      s.total_nodes  = nodes_seen;
      s.total_leaves = leaves_seen;
      s.total_inner  = (nodes_seen >= leaves_seen) ? nodes_seen - leaves_seen : '0;
      s.highest_rank = widest_rank;
      s.bifurcating  = (widest_rank == 2);
      step_results = {step_results, s};
      clear_tree_state();
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size()-1].last_result = 1'b1;
    end
    awaited_results = {awaited_results, step_results};
    step_results.delete();
  endfunction

  function automatic string describe(ptrv_pkg::result_t r);
    return $sformatf({"kind %0d index %0d rank %0d ok %0d valid %0d nodes %0d leaves %0d ",
                      "inner %0d highest %0d bif %0d last %0d"},
                     r.kind, r.node_index, r.node_rank, r.node_ok, r.tree_valid,
                     r.total_nodes, r.total_leaves, r.total_inner, r.highest_rank,
                     r.bifurcating, r.last_result);
  endfunction

  task automatic send_node(depth_t d, logic lf, logic fin);
    int gap;
    @(negedge clk_i);
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    node_depth_i = d;
    leaf_flag_i  = lf;
    final_node_i = fin;
    do @(posedge clk_i); while (!in_ready_o);
    track_node(d, lf, fin);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_shape_node(depth_t d, logic lf, logic fin);
    shape_depth = {shape_depth, d};
    shape_leaf  = {shape_leaf, lf};
    shape_final = {shape_final, fin};
  endfunction

  // Random well-formed subtree; leaf flags follow the child count unless flipped.
  function automatic void grow(int d);
    int   kids;
    int   pick;
    logic lf;
    grow_room--;
    pick = $urandom_range(0, 99);
    if (d >= 31 || grow_room <= 0 || pick < 30) begin
      kids = 0;
    end else if (pick < 38) begin
      kids = 1;
    end else if (pick < 85) begin
      kids = 2;
    end else begin
      kids = 3;
    end
    lf = (kids == 0);
    if ($urandom_range(0, 24) == 0) lf = !lf;
    add_shape_node(depth_t'(d), lf, 1'b0);
    for (int k = 0; k < kids; k++) grow(d + 1);
  endfunction

  // A bifurcating spine: each inner node has a leaf and the next spine node.
  function automatic void build_spine(int levels);
    for (int k = 0; k < levels; k++) begin
      add_shape_node(depth_t'(k), 1'b0, 1'b0);
      add_shape_node(depth_t'(k + 1), 1'b1, 1'b0);
    end
    add_shape_node(depth_t'(levels), 1'b1, 1'b1);
  endfunction

  function automatic void mark_shape_end();
    shape_final[shape_final.size()-1] = 1'b1;
  endfunction

  task automatic send_shape();
    for (int i = 0; i < shape_depth.size(); i++) begin
      send_node(shape_depth[i], shape_leaf[i], shape_final[i]);
    end
    shape_depth.delete();
    shape_leaf.delete();
    shape_final.delete();
  endtask

  task automatic test_lone_root();
    send_node(5'd0, 1'b1, 1'b1);
    send_node(5'd0, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_small_trees();
    send_node(5'd0, 1'b0, 1'b0);
    send_node(5'd1, 1'b0, 1'b0);
    send_node(5'd2, 1'b1, 1'b0);
    send_node(5'd2, 1'b1, 1'b0);
    send_node(5'd1, 1'b1, 1'b1);
    send_node(5'd0, 1'b1, 1'b0);
    send_node(5'd1, 1'b1, 1'b0);
    send_node(5'd1, 1'b1, 1'b0);
    send_node(5'd1, 1'b0, 1'b0);
    send_node(5'd2, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_depth_jumps();
    send_node(5'd2, 1'b1, 1'b1);
    send_node(5'd0, 1'b0, 1'b0);
    send_node(5'd1, 1'b0, 1'b0);
    send_node(5'd31, 1'b1, 1'b0);
    send_node(5'd0, 1'b1, 1'b0);
    send_node(5'd0, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_trees();
    int goal;
    int pick;
    int n;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        grow_room = $urandom_range(1, 16);
        grow(0);
        if ($urandom_range(0, 4) == 0) begin
          grow_room = $urandom_range(1, 6);
          grow(0);
        end
        mark_shape_end();
      end else if (pick < 70) begin
        build_spine($urandom_range(1, 10));
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          add_shape_node(depth_t'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                         (i == n - 1) || ($urandom_range(0, 5) == 0));
        end
      end
      send_shape();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    build_spine(31);
    send_shape();
    grow_room = 8;
    grow(0);
    mark_shape_end();
    send_shape();
    wait_drained();
  endtask

  initial begin : drive_out_ready
    int stall;
    stall       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else if (rx_gaps_on && $urandom_range(0, 6) == 0) begin
        stall = idle_len();
        if (stall > 0) begin
          out_ready_i = 1'b0;
          stall--;
        end else begin
          out_ready_i = 1'b1;
        end
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    ptrv_pkg::result_t seen;
    ptrv_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.kind         = kind_o;
      seen.node_index   = node_index_o;
      seen.node_rank    = node_rank_o;
      seen.node_ok      = node_ok_o;
      seen.tree_valid   = tree_valid_o;
      seen.total_nodes  = total_nodes_o;
      seen.total_leaves = total_leaves_o;
      seen.total_inner  = total_inner_o;
      seen.highest_rank = highest_rank_o;
      seen.bifurcating  = bifurcating_o;
      seen.last_result  = last_result_o;
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected result: %s", describe(seen));
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        if (seen !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(seen));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("preorder_tree_rank_validator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    node_depth_i = '0;
    leaf_flag_i  = 1'b0;
    final_node_i = 1'b0;
    clear_tree_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_lone_root();
    test_small_trees();
    test_depth_jumps();
    test_random_trees();
    test_backpressure();

    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("preorder_tree_rank_validator verification clean");
    end else begin
      $display("preorder_tree_rank_validator verification failed");
    end
    $finish;
  end

endmodule
